FILE: rtl/plq_pkg.sv
// Package for the Paxos learner quorum table.
// Holds table sizing, the table entry layout, result status codes and the
// command/status structs between controller and datapath. No dependencies.
package plq_pkg;

    localparam int INSTANCES  = 1024;
    localparam int VALUE_BITS = 64;
    localparam int IDX_W      = (INSTANCES > 1) ? $clog2(INSTANCES) : 1;

    // Result status codes.
    localparam logic [2:0] STAT_STALE   = 3'd0;
    localparam logic [2:0] STAT_COUNTED = 3'd1;
    localparam logic [2:0] STAT_ADOPTED = 3'd2;
    localparam logic [2:0] STAT_CHOSEN  = 3'd3;
    localparam logic [2:0] STAT_DROPPED = 3'd4;

    localparam logic [5:0] ACC_COUNT_RST = 6'd3;

    typedef struct packed {
        logic [31:0]           round;
        logic [31:0]           voters;
        logic [7:0]            votes;
        logic [VALUE_BITS-1:0] value;
    } entry_t;

    // Controller to datapath.
    typedef struct packed {
        logic clear_wr;   // write a zero entry at the clear pointer
        logic capture;    // load the incoming vote
        logic commit;     // write back the entry and load the result register
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic clear_last; // clear pointer is at the last entry
    } sts_t;

endpackage

FILE: rtl/plq_ctrl.sv
// Controller state machine for the Paxos learner quorum table.
// Sequences the clearing pass and the read/update of each vote and owns the
// result valid flag. Depends on plq_pkg.
module plq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output plq_pkg::cmd_t cmd,
    input  plq_pkg::sts_t sts
);
    import plq_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_READ   = 4'b0100,
        ST_UPDATE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd.clear_wr = 1'b0;
        cmd.capture  = 1'b0;
        cmd.commit   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (state_reg == ST_UPDATE) && slot_free)
        else $error("commit without a free result slot");

    a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_READ))
        else $error("accepted vote did not start a table read");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !out_valid_reg && !in_ready)
        else $error("traffic during the clearing pass");
`endif

endmodule

FILE: rtl/plq_dp.sv
// Datapath for the Paxos learner quorum table.
// Holds the table memory, the captured vote, the acceptor-count register, the
// entry update logic and the result register. Depends on plq_pkg.
module plq_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  plq_pkg::cmd_t         cmd,
    output plq_pkg::sts_t         sts,
    input  logic                  cfg_wr_en,
    input  logic [5:0]            cfg_wr_data,
    input  logic [15:0]           instance_req,
    input  logic [31:0]           round,
    input  logic [4:0]            acceptor_id,
    input  logic [63:0]           vote_value,
    output logic [2:0]            status,
    output logic [15:0]           out_instance,
    output logic [63:0]           chosen_value,
    output logic [7:0]            vote_count,
    output logic [31:0]           voter_mask
);
    import plq_pkg::*;

    entry_t                mem [INSTANCES];
    entry_t                rd_reg;
    entry_t                upd;
    logic [IDX_W-1:0]      clr_ptr_reg;
    logic [5:0]            num_acc_reg;
    logic [15:0]           inst_reg;
    logic [31:0]           round_reg;
    logic [4:0]            aid_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [IDX_W-1:0]      idx;
    logic                  in_range;
    logic                  rnd_eq;
    logic                  rnd_hi;
    logic [31:0]           voter_bit;
    logic [6:0]            acc_sum;
    logic [5:0]            quorum;
    logic [2:0]            stat;

    logic [2:0]            status_reg;
    logic [15:0]           out_inst_reg;
    logic [63:0]           value_reg;
    logic [7:0]            count_reg;
    logic [31:0]           mask_reg;

    assign idx      = inst_reg[IDX_W-1:0];
    assign in_range = {1'b0, inst_reg} < 17'(INSTANCES);
    assign sts.clear_last = (clr_ptr_reg == IDX_W'(INSTANCES - 1));

    // Quorum is ceil((n+1)/2) = (n+2)/2.
    assign acc_sum = {1'b0, num_acc_reg} + 7'd2;
    assign quorum  = acc_sum[6:1];

    assign rnd_eq    = (round_reg == rd_reg.round);
    assign rnd_hi    = (round_reg > rd_reg.round);
    assign voter_bit = 32'b1 << aid_reg;

    always_comb
    begin
        upd = rd_reg;
        if (rnd_eq)
        begin
            upd.voters = rd_reg.voters | voter_bit;
            upd.votes  = (rd_reg.votes == 8'hFF) ? 8'hFF : rd_reg.votes + 8'd1;
            if (rd_reg.value[7:0] == 8'd0)
            begin
                upd.value = val_reg;
            end
        end
        else if (rnd_hi)
        begin
            upd.round  = round_reg;
            upd.voters = rd_reg.voters | voter_bit;
            upd.votes  = 8'd1;
            upd.value  = val_reg;
        end
    end

    always_comb
    begin
        if (!in_range)
        begin
            stat = STAT_DROPPED;
        end
        else if (rnd_eq)
        begin
            stat = (upd.votes >= {2'b00, quorum}) ? STAT_CHOSEN : STAT_COUNTED;
        end
        else if (rnd_hi)
        begin
            stat = STAT_ADOPTED;
        end
        else
        begin
            stat = STAT_STALE;
        end
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr)
        begin
            mem[clr_ptr_reg] <= '0;
        end
        else if (cmd.commit && in_range)
        begin
            mem[idx] <= upd;
        end
        rd_reg <= mem[idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_ptr_reg <= '0;
            num_acc_reg <= ACC_COUNT_RST;
        end
        else
        begin
            if (cmd.clear_wr && !sts.clear_last)
            begin
                clr_ptr_reg <= clr_ptr_reg + IDX_W'(1);
            end
            if (cfg_wr_en)
            begin
                num_acc_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            inst_reg  <= instance_req;
            round_reg <= round;
            aid_reg   <= acceptor_id;
            val_reg   <= vote_value[VALUE_BITS-1:0];
        end
        if (cmd.commit)
        begin
            status_reg   <= stat;
            out_inst_reg <= inst_reg;
            if (in_range)
            begin
                value_reg <= 64'(upd.value);
                count_reg <= upd.votes;
                mask_reg  <= upd.voters;
            end
            else
            begin
                value_reg <= '0;
                count_reg <= '0;
                mask_reg  <= '0;
            end
        end
    end

    assign status       = status_reg;
    assign out_instance = out_inst_reg;
    assign chosen_value = value_reg;
    assign vote_count   = count_reg;
    assign voter_mask   = mask_reg;

`ifndef SYNTHESIS
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !in_range) |=> (status_reg == STAT_DROPPED) && (mask_reg == 32'd0))
        else $error("dropped vote reported table contents");

    a_adopt_one: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && in_range && rnd_hi) |=> (count_reg == 8'd1))
        else $error("new round did not restart the count at one");

    a_chosen_quorum: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && (stat == STAT_CHOSEN)) |-> (upd.votes >= {2'b00, quorum}))
        else $error("chosen reported below quorum");
`endif

endmodule

FILE: rtl/paxos_learner_quorum_table.sv
// Top level of the Paxos learner quorum table.
// Joins the controller (plq_ctrl) and the datapath (plq_dp); uses plq_pkg.
//
//   Channel  | Handshake            | Carries
//   ---------+----------------------+-------------------------------------------------
//   in       | in_valid / in_ready  | instance_req, round, acceptor_id, vote_value
//   out      | out_valid / out_ready| status, out_instance, chosen_value, vote_count,
//            |                      | voter_mask
//   cfg      | cfg_wr_en            | cfg_wr_data (acceptor count)
//
// Each vote transaction runs through three steps: accept, table read, and update with
// write-back; the table read with a registered output makes the separate read step necessary.
// After reset a clearing pass zeroes the table, one entry per cycle, over all 1024
// entries (INSTANCES); in_ready stays low during it, configuration writes are taken.
// The result sits in an output register, so the next vote is accepted while a
// result waits; the update stage holds only while that register is still full.
module paxos_learner_quorum_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] instance_req,
    input  logic [31:0] round,
    input  logic [4:0]  acceptor_id,
    input  logic [63:0] vote_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [15:0] out_instance,
    output logic [63:0] chosen_value,
    output logic [7:0]  vote_count,
    output logic [31:0] voter_mask
);
    import plq_pkg::*;

    // Command and status bundles between the state machine and the datapath.
    cmd_t cmd;
    sts_t sts;

    // The controller owns sequencing and the result valid flag.
    plq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // The datapath holds the table, the vote update rules and the result fields.
    plq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .instance_req (instance_req),
        .round        (round),
        .acceptor_id  (acceptor_id),
        .vote_value   (vote_value),
        .status       (status),
        .out_instance (out_instance),
        .chosen_value (chosen_value),
        .vote_count   (vote_count),
        .voter_mask   (voter_mask)
    );

endmodule
